// ===== rtl/brlsq_pkg.sv =====
// shared types and constants of the beeper run-length sample queue
// no dependencies; imported by every module of the block
package brlsq_pkg;

  localparam int RING_DEPTH = 8192;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int ACC_W      = 24;
  localparam int PER_W      = 16;
  localparam int THR_W      = 8;
  localparam int VOL_W      = 8;
  localparam int RUN_W      = 16;
  localparam int ELAP_W     = 12;
  localparam int DIV_STEPS  = ACC_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [PER_W-1:0] TPS_RST    = 16'd40570;
  localparam logic [THR_W-1:0] THR_RST    = 8'd80;
  localparam logic [VOL_W-1:0] VOL_RST    = 8'd128;
  localparam logic [RUN_W-1:0] PREBUF_RST = 16'd4000;

  typedef enum logic [1:0] {
    CFG_TPS    = 2'd0,
    CFG_THR    = 2'd1,
    CFG_VOL    = 2'd2,
    CFG_PREBUF = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_ACCUM   = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_SAMPLE  = 3'd3,
    ST_SILENCE = 3'd4
  } res_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_CMP,
    S_DIV,
    S_CHK,
    S_SUB,
    S_PULL_RD,
    S_PULL_WR,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic              func;
    logic [ELAP_W-1:0] elapsed_tstates;
    logic              speaker_level;
    logic              pull_last;
  } in_word_t;

  typedef struct packed {
    logic [VOL_W-1:0] sample_value;
    logic [2:0]       status;
    logic [RUN_W-1:0] run_samples;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic acc_add;
    logic res_accum;
    logic div_init;
    logic div_step;
    logic mul;
    logic commit_adv;
    logic pull_silence;
    logic pull_rd;
    logic pull_commit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic below_limit;
    logic div_last;
    logic quot_zero;
    logic pull_empty;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/brlsq_ctrl.sv =====
// sequencing state machine of the beeper run-length sample queue
// depends on brlsq_pkg; drives datapath commands from datapath status
module brlsq_ctrl
  import brlsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_func ? S_PULL_RD : S_ADD;
        end
      end
      S_ADD:     state_nxt = S_CMP;
      S_CMP:     state_nxt = stat.below_limit ? S_OUT : S_DIV;
      S_DIV: begin
        if (stat.div_last) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK:     state_nxt = stat.quot_zero ? S_OUT : S_SUB;
      S_SUB:     state_nxt = S_OUT;
      S_PULL_RD: state_nxt = stat.pull_empty ? S_OUT : S_PULL_WR;
      S_PULL_WR: state_nxt = S_OUT;
      S_OUT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_ADD: cmd.acc_add = 1'b1;
      S_CMP: begin
        cmd.res_accum = stat.below_limit;
        cmd.div_init  = !stat.below_limit;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_CHK: begin
        cmd.res_accum = stat.quot_zero;
        cmd.mul       = !stat.quot_zero;
      end
      S_SUB: cmd.commit_adv = 1'b1;
      S_PULL_RD: begin
        cmd.pull_silence = stat.pull_empty;
        cmd.pull_rd      = !stat.pull_empty;
      end
      S_PULL_WR: cmd.pull_commit = 1'b1;
      S_OUT: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/brlsq_dp.sv =====
// datapath: config registers, time accumulator, bit-serial divider, run ring, output register
// depends on brlsq_pkg; steered by brlsq_ctrl through dp_cmd_t
module brlsq_dp
  import brlsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  in_word_t   in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output out_word_t  out_data,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat
);

  // configuration
  logic [PER_W-1:0] tps_r;
  logic [THR_W-1:0] thr_r;
  logic [VOL_W-1:0] vol_r;
  logic [RUN_W-1:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= TPS_RST;
      thr_r    <= THR_RST;
      vol_r    <= VOL_RST;
      target_r <= PREBUF_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TPS:    tps_r    <= cfg_wdata;
        CFG_THR:    thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_VOL:    vol_r    <= cfg_wdata[VOL_W-1:0];
        CFG_PREBUF: target_r <= cfg_wdata;
      endcase
    end
  end

  logic [PER_W-1:0] period;
  assign period = (tps_r == '0) ? PER_W'(1) : tps_r;

  // latched word
  in_word_t in_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  // accumulator and threshold
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] limit_r;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] prod_r;
  logic [31:0]      prod;

  assign acc_sum = {1'b0, acc_r} + {(ACC_W+1-ELAP_W-8)'(0), in_r.elapsed_tstates, 8'd0};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_add) begin
      acc_nxt = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end else if (cmd.commit_adv) begin
      acc_nxt = acc_r - prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_add) begin
      limit_r <= period * thr_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [ACC_W-1:0]  quo_r;
  logic [PER_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [PER_W:0]    trial;
  logic              fits;
  logic [RUN_W-1:0]  nsat;
  logic [RUN_W-1:0]  n_r;

  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign fits  = (trial >= {1'b0, period});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r  <= acc_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[ACC_W-2:0], fits};
      rem_r  <= fits ? PER_W'(trial - {1'b0, period}) : trial[PER_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // run length saturates at 16 bits
  assign nsat = (quo_r[ACC_W-1:RUN_W] != '0) ? '1 : quo_r[RUN_W-1:0];
  assign prod = nsat * period;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      n_r    <= nsat;
      prod_r <= prod[ACC_W-1:0];
    end
  end

  // run ring
  logic [RUN_W:0]   mem [RING_DEPTH];
  logic [RUN_W:0]   rd_r;
  logic [IDX_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] queued_r;
  logic [RUN_W-1:0] prebuf_r;
  logic             playing_r;
  logic             full;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [RUN_W:0]   mem_wdata;
  logic [RUN_W-1:0] len_dec;
  logic [RUN_W:0]   pb_sum;
  logic [RUN_W-1:0] pb_sat;

  assign full    = (queued_r == CNT_W'(RING_DEPTH));
  assign len_dec = (rd_r[RUN_W-1:0] != '0) ? rd_r[RUN_W-1:0] - RUN_W'(1) : '0;
  assign pb_sum  = {1'b0, prebuf_r} + {1'b0, n_r};
  assign pb_sat  = pb_sum[RUN_W] ? '1 : pb_sum[RUN_W-1:0];

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = tail_r;
    mem_wdata = {in_r.speaker_level, n_r};
    if (cmd.commit_adv && !full) begin
      mem_we = 1'b1;
    end else if (cmd.pull_commit) begin
      mem_we    = 1'b1;
      mem_addr  = head_r;
      mem_wdata = {rd_r[RUN_W], len_dec};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pull_rd) begin
      rd_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      queued_r  <= '0;
      prebuf_r  <= '0;
      playing_r <= 1'b0;
    end else begin
      if (cmd.commit_adv && !full) begin
        tail_r   <= ring_next(tail_r);
        queued_r <= queued_r + CNT_W'(1);
        prebuf_r <= pb_sat;
        if (pb_sat > target_r) begin
          playing_r <= 1'b1;
        end
      end
      if (cmd.pull_commit && len_dec == '0) begin
        head_r   <= ring_next(head_r);
        queued_r <= queued_r - CNT_W'(1);
      end
      // last pull of a buffer restarts the prebuffer count
      if ((cmd.pull_commit || cmd.pull_silence) && in_r.pull_last) begin
        prebuf_r <= '0;
      end
    end
  end

  // result staging and output register
  out_word_t res_r;
  logic      out_valid_r;
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.res_accum) begin
      res_r <= '{sample_value: '0, status: ST_ACCUM, run_samples: '0};
    end else if (cmd.commit_adv) begin
      res_r <= '{sample_value: '0, status: full ? ST_DROPPED : ST_QUEUED, run_samples: n_r};
    end else if (cmd.pull_silence) begin
      res_r <= '{sample_value: '0, status: ST_SILENCE, run_samples: '0};
    end else if (cmd.pull_commit) begin
      res_r <= '{sample_value: rd_r[RUN_W] ? vol_r : '0, status: ST_SAMPLE,
                 run_samples: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.below_limit = (acc_r < limit_r);
  assign stat.div_last    = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign stat.quot_zero   = (quo_r == '0);
  assign stat.pull_empty  = !playing_r || (queued_r == '0);
  assign stat.out_free    = !out_valid_r || !out_stall;

endmodule

// ===== rtl/beeper_run_length_sample_queue_top.sv =====
// beeper run-length sample queue top level; depends on brlsq_pkg, brlsq_ctrl, brlsq_dp
// from accept to out_valid: an advance runs add and compare and, below threshold, goes to output;
// else the divide (24 divider steps), multiply and subtract, which a zero quotient skips; a pull
// reads the ring and writes back the run, which silence skips; no word is taken before the last
// result loads, the next the cycle after; out_stall on the output register delays the load
// synchronous active-low reset clears control, accumulator, indices and out_valid, loads config defaults, not the ring
module beeper_run_length_sample_queue_top
  import brlsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  brlsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  brlsq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
